// ----- hdl/ibt_pkg.sv -----
// ----------------------------------------------------------------------------
// ibt_pkg
// Shared types, codes and defaults for the input binding table.
// ----------------------------------------------------------------------------
package ibt_pkg;

   localparam int TABLE_ENTRIES_DEF = 64;
   localparam int ACTION_BYTES_DEF  = 16;
   localparam int BITS_PER_BYTE     = 8;
   localparam int KEY_W             = 18;
   localparam int ACT_W             = 7;
   localparam int ENTRY_W           = KEY_W + ACT_W;

   localparam logic [2:0] CMD_SET      = 3'd0;
   localparam logic [2:0] CMD_UNBIND   = 3'd1;
   localparam logic [2:0] CMD_LOOKUP   = 3'd2;
   localparam logic [2:0] CMD_SCAN     = 3'd3;
   localparam logic [2:0] CMD_END_SCAN = 3'd4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_MISS = 2'd2;

   typedef struct packed {
      logic [2:0] cmd;
      logic [1:0] device_class;
      logic [7:0] device_index;
      logic [7:0] control_index;
      logic [6:0] action_in;
   } ibt_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       found;
      logic [6:0] action_out;
      logic       newly_pressed;
   } ibt_rsp_type;

   typedef struct packed {
      logic [2:0]       cmd;
      logic [KEY_W-1:0] key;
      logic [ACT_W-1:0] act;
   } ibt_job_type;

endpackage

// ----- hdl/ibt_ram.sv -----
// ----------------------------------------------------------------------------
// ibt_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ibt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ----- hdl/ibt_front.sv -----
// ----------------------------------------------------------------------------
// ibt_front
// Two-entry request queue; turns each item into a job with a packed key.
// ----------------------------------------------------------------------------
module ibt_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  ibt_pkg::ibt_req_type req_item,
   output logic                 job_valid,
   input  logic                 job_pop,
   output ibt_pkg::ibt_job_type job
);

   ibt_pkg::ibt_job_type slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok, pop_ok;
   ibt_pkg::ibt_job_type job_new;

   assign req_full  = (cnt_ff == 2'd2);
   assign job_valid = (cnt_ff != 2'd0);
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = job_pop && job_valid;
   assign job       = slot_ff[rptr_ff];

   always_comb begin
      job_new.cmd = req_item.cmd;
      job_new.key = {req_item.device_class, req_item.device_index, req_item.control_index};
      job_new.act = req_item.action_in;
      wptr_in = push_ok ? ~wptr_ff : wptr_ff;
      rptr_in = pop_ok ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push_ok) begin
         slot_ff[wptr_ff] <= job_new;
      end
   end

endmodule

// ----- hdl/ibt_back.sv -----
// ----------------------------------------------------------------------------
// ibt_back
// Sequencer: sorted-table search, shift insert/delete, action bit tracking.
// ----------------------------------------------------------------------------
module ibt_back #(
   parameter int TABLE_ENTRIES = ibt_pkg::TABLE_ENTRIES_DEF,
   parameter int ACTION_BYTES  = ibt_pkg::ACTION_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_pop,
   input  ibt_pkg::ibt_job_type job,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output ibt_pkg::ibt_rsp_type rsp_item
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int AB = ACTION_BYTES * ibt_pkg::BITS_PER_BYTE;
   localparam int BW = $clog2(AB);
   localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SRD  = 3'd1;
   localparam logic [2:0] S_SCMP = 3'd2;
   localparam logic [2:0] S_DEC  = 3'd3;
   localparam logic [2:0] S_SHRD = 3'd4;
   localparam logic [2:0] S_SHWR = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] count_ff, count_in;
   logic          hit_ff, hit_in;
   logic          ins_ff, ins_in;
   logic [ibt_pkg::ACT_W-1:0] hact_ff, hact_in;
   ibt_pkg::ibt_job_type job_ff, job_in;
   logic [AB-1:0] cur_ff, cur_in;
   logic [AB-1:0] prev_ff, prev_in;
   ibt_pkg::ibt_rsp_type res_ff, res_in;
   logic          rv_ff, rv_in;

   logic                        we;
   logic [AW-1:0]               waddr, raddr;
   logic [ibt_pkg::ENTRY_W-1:0] wdata, rdata;
   logic [ibt_pkg::KEY_W-1:0]   rkey;
   logic [CW-1:0]               ptr_m1, ptr_p1;
   logic [7:0]                  a8;
   logic                        a_in_range;
   logic [BW-1:0]               bidx;

   ibt_ram #(.WIDTH(ibt_pkg::ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign rkey       = rdata[ibt_pkg::ENTRY_W-1:ibt_pkg::ACT_W];
   assign ptr_m1     = ptr_ff - 1'b1;
   assign ptr_p1     = ptr_ff + 1'b1;
   assign a8         = {1'b0, hact_ff};
   assign a_in_range = ({1'b0, a8} < 9'(AB));
   assign bidx       = a8[BW-1:0];
   assign rsp_empty  = !rv_ff;
   assign rsp_item   = res_ff;

   always_comb begin
      state_in = state_ff;
      ptr_in   = ptr_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      hit_in   = hit_ff;
      ins_in   = ins_ff;
      hact_in  = hact_ff;
      job_in   = job_ff;
      cur_in   = cur_ff;
      prev_in  = prev_ff;
      res_in   = res_ff;
      rv_in    = rv_ff;
      job_pop  = 1'b0;
      we       = 1'b0;
      waddr    = ptr_ff[AW-1:0];
      wdata    = rdata;
      raddr    = ptr_ff[AW-1:0];
      if (rsp_pop && rv_ff) begin
         rv_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (job_valid && !rv_ff) begin
               job_pop = 1'b1;
               job_in  = job;
               ptr_in  = '0;
               res_in  = '0;
               unique case (job.cmd)
                  ibt_pkg::CMD_SET, ibt_pkg::CMD_UNBIND,
                  ibt_pkg::CMD_LOOKUP, ibt_pkg::CMD_SCAN: begin
                     state_in = S_SRD;
                  end
                  ibt_pkg::CMD_END_SCAN: begin
                     prev_in = cur_ff;
                     cur_in  = '0;
                     rv_in   = 1'b1;
                  end
                  default: begin
                     rv_in = 1'b1;
                  end
               endcase
            end
         end
         S_SRD: begin
            if (ptr_ff == count_ff) begin
               pos_in   = count_ff;
               hit_in   = 1'b0;
               state_in = S_DEC;
            end else begin
               state_in = S_SCMP;
            end
         end
         S_SCMP: begin
            if (rkey >= job_ff.key) begin
               pos_in   = ptr_ff;
               hit_in   = (rkey == job_ff.key);
               hact_in  = rdata[ibt_pkg::ACT_W-1:0];
               state_in = S_DEC;
            end else begin
               ptr_in   = ptr_p1;
               state_in = S_SRD;
            end
         end
         S_DEC: begin
            state_in = S_IDLE;
            rv_in    = 1'b1;
            unique case (job_ff.cmd)
               ibt_pkg::CMD_SET: begin
                  if (hit_ff) begin
                     we    = 1'b1;
                     waddr = pos_ff[AW-1:0];
                     wdata = {job_ff.key, job_ff.act};
                  end else if (count_ff == FULL_CNT) begin
                     res_in.status = ibt_pkg::ST_FULL;
                  end else begin
                     ptr_in   = count_ff;
                     ins_in   = 1'b1;
                     rv_in    = 1'b0;
                     state_in = S_SHRD;
                  end
               end
               ibt_pkg::CMD_UNBIND: begin
                  if (hit_ff) begin
                     ptr_in   = pos_ff;
                     ins_in   = 1'b0;
                     rv_in    = 1'b0;
                     state_in = S_SHRD;
                  end else begin
                     res_in.status = ibt_pkg::ST_MISS;
                  end
               end
               ibt_pkg::CMD_LOOKUP: begin
                  if (hit_ff) begin
                     res_in.found      = 1'b1;
                     res_in.action_out = hact_ff;
                  end else begin
                     res_in.status = ibt_pkg::ST_MISS;
                  end
               end
               ibt_pkg::CMD_SCAN: begin
                  if (hit_ff) begin
                     res_in.found      = 1'b1;
                     res_in.action_out = hact_ff;
                     if (a_in_range) begin
                        res_in.newly_pressed = !prev_ff[bidx];
                        cur_in[bidx]         = 1'b1;
                     end else begin
                        res_in.newly_pressed = 1'b1;
                     end
                  end else begin
                     res_in.status = ibt_pkg::ST_MISS;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SHRD: begin
            if (ins_ff) begin
               if (ptr_ff == pos_ff) begin
                  we       = 1'b1;
                  waddr    = pos_ff[AW-1:0];
                  wdata    = {job_ff.key, job_ff.act};
                  count_in = count_ff + 1'b1;
                  rv_in    = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  raddr    = ptr_m1[AW-1:0];
                  state_in = S_SHWR;
               end
            end else begin
               if (ptr_p1 >= count_ff) begin
                  count_in = count_ff - 1'b1;
                  rv_in    = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  raddr    = ptr_p1[AW-1:0];
                  state_in = S_SHWR;
               end
            end
         end
         S_SHWR: begin
            we       = 1'b1;
            waddr    = ptr_ff[AW-1:0];
            wdata    = rdata;
            ptr_in   = ins_ff ? ptr_m1 : ptr_p1;
            state_in = S_SHRD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         cur_ff   <= '0;
         prev_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cur_ff   <= cur_in;
         prev_ff  <= prev_in;
         rv_ff    <= rv_in;
      end
      ptr_ff  <= ptr_in;
      pos_ff  <= pos_in;
      hit_ff  <= hit_in;
      ins_ff  <= ins_in;
      hact_ff <= hact_in;
      job_ff  <= job_in;
      res_ff  <= res_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("binding count above table size");

   a_busy_no_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rv_ff)
      else $error("result pending while sequencer busy");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + 1'b1 || count_ff == $past(count_ff) - 1'b1))
      else $error("binding count jumped");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_SRD || state_ff == S_SCMP) |-> !we)
      else $error("table written during search");

endmodule

// ----- hdl/input_binding_table.sv -----
// ----------------------------------------------------------------------------
// input_binding_table
// Sorted control-to-action binding table with per-scan press detection.
// ----------------------------------------------------------------------------
// Flow: end_scan and unused codes post their result straight from idle;
//   lookup, scan and set update search entry by entry, then decide;
//   insert and delete then shift the later entries to open or close the
//   found slot. Search and shift together walk the table once.
// Throughput: one item at a time in the sequencer; the next starts the cycle
//   after the result is taken. A two-entry request queue buffers the input.
// Reset: synchronous; clears binding count and action bits, table RAM is not.
module input_binding_table #(
   parameter int TABLE_ENTRIES = ibt_pkg::TABLE_ENTRIES_DEF,
   parameter int ACTION_BYTES  = ibt_pkg::ACTION_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  ibt_pkg::ibt_req_type req_item,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output ibt_pkg::ibt_rsp_type rsp_item
);

   logic                 job_valid;
   logic                 job_pop;
   ibt_pkg::ibt_job_type job;

   ibt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .job_valid (job_valid),
      .job_pop   (job_pop),
      .job       (job)
   );

   ibt_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .ACTION_BYTES  (ACTION_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_pop   (job_pop),
      .job       (job),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule
